// ----- rtl/bgd_pkg.sv -----
// Shared types and constants for the button gesture detector.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bgd_pkg;

  // Field widths fixed by the stream format
  localparam int MASK_W  = 4;
  localparam int REG_W   = 16;
  localparam int IDX_W   = 1;
  localparam int S_DATA_W = 8;
  localparam int M_DATA_W = 24;

  // Command codes carried on s_tuser
  localparam logic CMD_STATUS = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_LONG_PRESS    = 1'b0;
  localparam logic [IDX_W-1:0] REG_DOUBLE_WINDOW = 1'b1;

  localparam logic [REG_W-1:0] REG_RESET_TICKS = 16'd1000;

  // Combo buttons: minus and plus
  localparam int COMBO_A = 0;
  localparam int COMBO_B = 2;

  // What one button lane reports for the current word
  typedef struct packed {
    logic up;        // up state after this word
    logic changed;
    logic pressed;
    logic dbl;
    logic lng;
  } lane_res_t;

  // What the combo timer reports for the current word
  typedef struct packed {
    logic pressed;
    logic fired;
  } combo_res_t;

endpackage

// ----- rtl/button_gesture_detector.sv -----
// Top level of the button gesture detector: config registers, button lanes,
// combo timer and the merging output register. Depends on bgd_pkg,
// bgd_lane and bgd_combo.
`timescale 1ns / 1ps

// Usage:
//   Input stream: s_tuser selects a status word (0) or a time tick (1);
//   s_tdata carries the present mask and the up mask of the buttons
//   minus, play/pause, plus and power (bits 0..3 of each mask).
//   Output stream: one result word per input word, packed on m_tdata.
//   Config port: write cfg_data to register cfg_index while cfg_we is high;
//   index 0 is the long-press time, index 1 the double-press window, both in
//   ticks. Write only while no word is in flight.
//   A result appears on m_tvalid in the cycle after its input is accepted.
//   Throughput: one word per cycle when not stalled, set by the single
//   output register; every lane updates its state in the accepting cycle.
//   A stalled receiver holds the output register; s_tready then drops until
//   the held word is taken, and is high again in the cycle it is taken.
//   Reset (rst, synchronous): all buttons up, all timers stopped, no press
//   history, both registers at 1000 ticks, output empty.
module button_gesture_detector
  import bgd_pkg::*;
#(
  parameter int NUM_BUTTONS = 4,
  parameter int TIMER_BITS  = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,  // [3:0] present_mask, [7:4] up_mask
  input  logic                s_tuser,  // [0] cmd
  output logic                m_tvalid,
  input  logic                m_tready,
  // [3:0] up_state, [7:4] changed, [11:8] pressed, [15:12] double_pressed,
  // [19:16] long_pressed, [20] combo_pressed, [21] combo_long, [23:22] zero
  output logic [M_DATA_W-1:0] m_tdata,
  input  logic                cfg_we,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [REG_W-1:0]    cfg_data
);

  logic             accept;
  logic [REG_W-1:0] long_ticks;
  logic [REG_W-1:0] dbl_ticks;
  logic [MASK_W-1:0] present_mask, up_mask;
  lane_res_t        lane_res [NUM_BUTTONS];
  combo_res_t       combo_res;
  logic             combo_up_a, combo_up_b;
  logic [MASK_W-1:0] up_state, changed, pressed, double_pressed, long_pressed;
  logic             out_valid;
  logic [M_DATA_W-1:0] out_data;

  assign present_mask = s_tdata[MASK_W-1:0];
  assign up_mask      = s_tdata[2*MASK_W-1:MASK_W];

  // Take a word whenever the output register is empty or draining
  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      long_ticks <= REG_RESET_TICKS;
      dbl_ticks  <= REG_RESET_TICKS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LONG_PRESS:    long_ticks <= cfg_data;
        REG_DOUBLE_WINDOW: dbl_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  // One lane per button; buttons past the mask width are never present
  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
    logic lane_present, lane_up;
    if (i < MASK_W) begin : g_io
      assign lane_present = present_mask[i];
      assign lane_up      = up_mask[i];
    end else begin : g_noio
      assign lane_present = 1'b0;
      assign lane_up      = 1'b1;
    end
    bgd_lane #(
      .TIMER_BITS(TIMER_BITS)
    ) u_lane (
      .clk       (clk),
      .rst       (rst),
      .accept    (accept),
      .cmd       (s_tuser),
      .present   (lane_present),
      .up_in     (lane_up),
      .long_ticks(long_ticks),
      .dbl_ticks (dbl_ticks),
      .res       (lane_res[i])
    );
  end

  // A combo button that does not exist counts as up
  if (COMBO_A < NUM_BUTTONS) begin : g_combo_a
    assign combo_up_a = lane_res[COMBO_A].up;
  end else begin : g_no_combo_a
    assign combo_up_a = 1'b1;
  end
  if (COMBO_B < NUM_BUTTONS) begin : g_combo_b
    assign combo_up_b = lane_res[COMBO_B].up;
  end else begin : g_no_combo_b
    assign combo_up_b = 1'b1;
  end

  bgd_combo #(
    .TIMER_BITS(TIMER_BITS)
  ) u_combo (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .cmd       (s_tuser),
    .up_a      (combo_up_a),
    .up_b      (combo_up_b),
    .long_ticks(long_ticks),
    .res       (combo_res)
  );

  // Merge lane reports into the four visible bit positions
  for (genvar i = 0; i < MASK_W; i++) begin : g_merge
    if (i < NUM_BUTTONS) begin : g_have
      assign up_state[i]       = lane_res[i].up;
      assign changed[i]        = lane_res[i].changed;
      assign pressed[i]        = lane_res[i].pressed;
      assign double_pressed[i] = lane_res[i].dbl;
      assign long_pressed[i]   = lane_res[i].lng;
    end else begin : g_none
      assign up_state[i]       = 1'b0;
      assign changed[i]        = 1'b0;
      assign pressed[i]        = 1'b0;
      assign double_pressed[i] = 1'b0;
      assign long_pressed[i]   = 1'b0;
    end
  end

  // Output register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= {2'b00, combo_res.fired, combo_res.pressed, long_pressed,
                   double_pressed, pressed, changed, up_state};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // An accepted word always shows up on the output next cycle
  a_accept_to_out: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted word did not reach the output register");

  // A press is always also a change
  a_press_is_change: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[11:8] & ~m_tdata[7:4]) == 4'b0000))
    else $error("press reported without a state change");

  // A double press is always also a press
  a_double_is_press: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[15:12] & ~m_tdata[11:8]) == 4'b0000))
    else $error("double press reported without a press");

  // Tick reports and status reports never mix in one word
  a_tick_vs_status: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && ((m_tdata[19:16] != 4'b0000) || m_tdata[21]))
      |-> ((m_tdata[7:4] == 4'b0000) && !m_tdata[20]))
    else $error("tick result carries status events");

endmodule

// ----- rtl/bgd_lane.sv -----
// One button lane: up state, long-press timer and double-press history.
// Depends on bgd_pkg.
`timescale 1ns / 1ps

module bgd_lane
  import bgd_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic             cmd,
  input  logic             present,
  input  logic             up_in,
  input  logic [REG_W-1:0] long_ticks,
  input  logic [REG_W-1:0] dbl_ticks,
  output lane_res_t        res
);

  localparam int CMP_W = (TIMER_BITS > REG_W) ? TIMER_BITS : REG_W;
  localparam logic [TIMER_BITS-1:0] CNT_MAX = '1;

  logic                  up, up_next;
  logic [TIMER_BITS-1:0] hold_cnt, hold_cnt_next;
  logic                  hold_run, hold_run_next;
  logic [TIMER_BITS-1:0] since, since_next;
  logic                  recent, recent_next;

  // Work out the lane's next state and its report for this word
  always_comb begin
    up_next       = up;
    hold_cnt_next = hold_cnt;
    hold_run_next = hold_run;
    since_next    = since;
    recent_next   = recent;
    res           = '0;
    if (cmd == CMD_STATUS) begin
      if (present && (up_in != up)) begin
        up_next     = up_in;
        res.changed = 1'b1;
        if (up_in) begin
          hold_run_next = 1'b0;
        end else begin
          res.pressed = 1'b1;
          // a second press inside the window consumes the history
          if (recent && (CMP_W'(since) < CMP_W'(dbl_ticks))) begin
            res.dbl     = 1'b1;
            recent_next = 1'b0;
          end else begin
            recent_next = 1'b1;
          end
          since_next    = '0;
          hold_cnt_next = '0;
          hold_run_next = 1'b1;
        end
      end
    end else begin
      // advance the saturating timers; the hold timer fires once and stops, the window timer just expires
      if (hold_run) begin
        hold_cnt_next = (hold_cnt == CNT_MAX) ? CNT_MAX : hold_cnt + 1'b1;
        if (CMP_W'(hold_cnt_next) >= CMP_W'(long_ticks)) begin
          hold_run_next = 1'b0;
          res.lng       = 1'b1;
        end
      end
      if (recent) begin
        since_next = (since == CNT_MAX) ? CNT_MAX : since + 1'b1;
        if (CMP_W'(since_next) >= CMP_W'(dbl_ticks)) begin
          recent_next = 1'b0;
        end
      end
    end
    res.up = up_next;
  end

  // Commit state when the word is accepted
  always_ff @(posedge clk) begin
    if (rst) begin
      up       <= 1'b1;
      hold_cnt <= '0;
      hold_run <= 1'b0;
      since    <= '0;
      recent   <= 1'b0;
    end else if (accept) begin
      up       <= up_next;
      hold_cnt <= hold_cnt_next;
      hold_run <= hold_run_next;
      since    <= since_next;
      recent   <= recent_next;
    end
  end

endmodule

// ----- rtl/bgd_combo.sv -----
// Minus-plus combo detector with its own long-press timer.
// Depends on bgd_pkg; fed by the up states that the lanes report.
`timescale 1ns / 1ps

module bgd_combo
  import bgd_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic             cmd,
  input  logic             up_a,
  input  logic             up_b,
  input  logic [REG_W-1:0] long_ticks,
  output combo_res_t       res
);

  localparam int CMP_W = (TIMER_BITS > REG_W) ? TIMER_BITS : REG_W;
  localparam logic [TIMER_BITS-1:0] CNT_MAX = '1;

  logic [TIMER_BITS-1:0] cnt, cnt_next;
  logic                  run, run_next;

  // Restart on every status word with both down, stop on any other status word; ticks advance the timer
  always_comb begin
    cnt_next = cnt;
    run_next = run;
    res      = '0;
    if (cmd == CMD_STATUS) begin
      if (!up_a && !up_b) begin
        res.pressed = 1'b1;
        cnt_next    = '0;
        run_next    = 1'b1;
      end else begin
        run_next = 1'b0;
      end
    end else if (run) begin
      cnt_next = (cnt == CNT_MAX) ? CNT_MAX : cnt + 1'b1;
      if (CMP_W'(cnt_next) >= CMP_W'(long_ticks)) begin
        run_next  = 1'b0;
        res.fired = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      run <= 1'b0;
    end else if (accept) begin
      cnt <= cnt_next;
      run <= run_next;
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for button_gesture_detector: drives status and tick words,
// predicts every result word in a behavioral model of the detector and compares them.
// Depends on bgd_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_top;
  import bgd_pkg::*;

  localparam logic [3:0] MINUS = 4'b0001;
  localparam logic [3:0] PLAY  = 4'b0010;
  localparam logic [3:0] PLUS  = 4'b0100;
  localparam logic [3:0] POWER = 4'b1000;
  localparam logic [3:0] NONE  = 4'b0000;
  localparam logic [3:0] ALL   = 4'b1111;
  localparam logic [15:0] CNT_TOP = 16'hFFFF;
  localparam int STALL_LIMIT = 1000;
  localparam int MAX_PRINTS  = 50;

  typedef struct packed {
    logic       cmd;
    logic [3:0] present;
    logic [3:0] upm;
  } button_word_t;

  typedef struct packed {
    logic [3:0] up_state;
    logic [3:0] changed;
    logic [3:0] pressed;
    logic [3:0] dbl;
    logic [3:0] lng;
    logic       combo_pressed;
    logic       combo_long;
  } gesture_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic                s_tuser = CMD_STATUS;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic                cfg_we = 1'b0;
  logic [IDX_W-1:0]    cfg_index = REG_LONG_PRESS;
  logic [REG_W-1:0]    cfg_data = '0;

  button_word_t button_words[$];
  gesture_t     gesture_q[$];
  int           errors = 0;
  bit           idle_on = 1'b0;
  bit           quiet = 1'b0;

  // Behavioral copy of the detector state and its registers
  logic [15:0] long_ticks = REG_RESET_TICKS;
  logic [15:0] window_ticks = REG_RESET_TICKS;
  logic [3:0]  btn_up = ALL;
  logic [15:0] hold_cnt [4];
  logic [3:0]  hold_run = NONE;
  logic [15:0] since_cnt [4];
  logic [3:0]  recent = NONE;
  logic [15:0] combo_cnt = '0;
  logic        combo_run = 1'b0;

  button_gesture_detector u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [15:0] sat_inc(logic [15:0] v);
    return (v == CNT_TOP) ? v : v + 16'd1;
  endfunction

  // Advance the gesture model by one word and return the result it must produce
  function automatic gesture_t classify_word(logic cmd, logic [3:0] present,
                                             logic [3:0] upm);
    gesture_t g;
    int i;
    g = '0;
    if (cmd == CMD_STATUS) begin
      for (i = 0; i < 4; i++) begin
        if (present[i] && upm[i] != btn_up[i]) begin
          btn_up[i] = upm[i];
          g.changed[i] = 1'b1;
          if (upm[i]) begin
            hold_run[i] = 1'b0;
          end else begin
            g.pressed[i] = 1'b1;
            // a press inside the window is a double and clears the history
            if (recent[i] && since_cnt[i] < window_ticks) begin
              g.dbl[i] = 1'b1;
              recent[i] = 1'b0;
            end else begin
              recent[i] = 1'b1;
            end
            since_cnt[i] = '0;
            hold_cnt[i] = '0;
            hold_run[i] = 1'b1;
          end
        end
      end
      if (!btn_up[COMBO_A] && !btn_up[COMBO_B]) begin
        g.combo_pressed = 1'b1;
        combo_cnt = '0;
        combo_run = 1'b1;
      end else begin
        combo_run = 1'b0;
      end
    end else begin
      for (i = 0; i < 4; i++) begin
        if (hold_run[i]) begin
          hold_cnt[i] = sat_inc(hold_cnt[i]);
          if (hold_cnt[i] >= long_ticks) begin
            hold_run[i] = 1'b0;
            g.lng[i] = 1'b1;
          end
        end
        if (recent[i]) begin
          since_cnt[i] = sat_inc(since_cnt[i]);
          if (since_cnt[i] >= window_ticks) recent[i] = 1'b0;
        end
      end
      if (combo_run) begin
        combo_cnt = sat_inc(combo_cnt);
        if (combo_cnt >= long_ticks) begin
          combo_run = 1'b0;
          g.combo_long = 1'b1;
        end
      end
    end
    g.up_state = btn_up;
    return g;
  endfunction

  task automatic report(string field, logic [3:0] got, logic [3:0] want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("mismatch in %s: got %h, expected %h at %0t", field, got, want, $realtime);
  endtask

  task automatic put(logic cmd, logic [3:0] present, logic [3:0] upm);
    button_word_t w;
    w.cmd = cmd;
    w.present = present;
    w.upm = upm;
    button_words.push_back(w);
  endtask

  // Mostly tidy presses, releases, combos and ticks, with some raw noise
  task automatic put_random;
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2, 3, 4: begin
        put(CMD_TICK, 4'($urandom), 4'($urandom));
      end
      5, 6: begin
        put(CMD_STATUS, 4'(1 << $urandom_range(0, 3)), 4'($urandom));
      end
      7: begin
        put(CMD_STATUS, MINUS | PLUS | 4'($urandom), 4'($urandom) & ~(MINUS | PLUS));
      end
      8: begin
        put(CMD_STATUS, 4'($urandom), 4'($urandom));
      end
      default: begin
        put(CMD_STATUS, ALL, ALL);
      end
    endcase
  endtask

  // Write one register while the block is idle; the model follows at once
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_LONG_PRESS) long_ticks = val;
    else window_ticks = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold until every queued word is taken and every result has come back
  task automatic drain;
    do @(negedge clk);
    while (button_words.size() != 0 || s_tvalid || gesture_q.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  // Input driver: present queued words, predict each one as it is accepted
  always @(posedge clk) begin : src_drv
    int gap;
    button_word_t w;
    if (rst) begin
      gap = 0;
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        gesture_q.push_back(classify_word(s_tuser, s_tdata[3:0], s_tdata[7:4]));
      if (!s_tvalid || s_tready) begin
        if (gap > 0) begin
          gap--;
          s_tvalid <= 1'b0;
        end else if (idle_on && !quiet && $urandom_range(0, 15) == 0) begin
          gap = $urandom_range(0, 18);
          s_tvalid <= 1'b0;
        end else if (button_words.size() != 0) begin
          w = button_words.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= w.cmd;
          s_tdata <= {w.upm, w.present};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: random back-pressure, compare each word with the oldest prediction
  always @(posedge clk) begin : sink_mon
    int gap;
    gesture_t e;
    if (rst) begin
      gap = 0;
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (gesture_q.size() == 0) begin
          report("unexpected word", m_tdata[3:0], NONE);
        end else begin
          e = gesture_q.pop_front();
          if (m_tdata[3:0] !== e.up_state) report("up_state", m_tdata[3:0], e.up_state);
          if (m_tdata[7:4] !== e.changed) report("changed", m_tdata[7:4], e.changed);
          if (m_tdata[11:8] !== e.pressed) report("pressed", m_tdata[11:8], e.pressed);
          if (m_tdata[15:12] !== e.dbl) report("double_pressed", m_tdata[15:12], e.dbl);
          if (m_tdata[19:16] !== e.lng) report("long_pressed", m_tdata[19:16], e.lng);
          if (m_tdata[20] !== e.combo_pressed)
            report("combo_pressed", 4'(m_tdata[20]), 4'(e.combo_pressed));
          if (m_tdata[21] !== e.combo_long)
            report("combo_long", 4'(m_tdata[21]), 4'(e.combo_long));
        end
      end
      if (gap > 0) begin
        gap--;
        m_tready <= 1'b0;
      end else if (idle_on && !quiet && $urandom_range(0, 11) == 0) begin
        gap = $urandom_range(0, 18);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin : watchdog
    int still;
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      still = 0;
    end else begin
      still++;
      if (still >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [15:0] long_set [8];
    logic [15:0] window_set [8];
    int p, n;
    long_set   = '{16'd1, 16'd2, 16'd7, 16'd12, 16'hFFFF, 16'd4, 16'd30, 16'd1};
    window_set = '{16'd1, 16'd5, 16'd3, 16'd20, 16'd6, 16'hFFFF, 16'd30, 16'd2};
    for (p = 0; p < 4; p++) begin
      hold_cnt[p] = '0;
      since_cnt[p] = '0;
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset timing: presses, releases, doubles, combo and ignored tick masks
    put(CMD_STATUS, ALL, ALL);
    put(CMD_TICK, ALL, NONE);
    put(CMD_STATUS, MINUS, NONE);
    put(CMD_STATUS, MINUS, ALL);
    put(CMD_STATUS, MINUS, NONE);
    put(CMD_STATUS, PLAY, NONE);
    put(CMD_STATUS, PLAY, ALL);
    put(CMD_STATUS, PLAY, NONE);
    put(CMD_STATUS, NONE, NONE);
    put(CMD_STATUS, MINUS | PLUS, NONE);
    put(CMD_STATUS, NONE, NONE);
    put(CMD_STATUS, ALL, ALL);
    put(CMD_STATUS, POWER, NONE);
    put(CMD_STATUS, POWER, ALL);
    drain();

    // Short timers: long press firing once, window aging, combo hold
    write_reg(REG_LONG_PRESS, 16'd3);
    write_reg(REG_DOUBLE_WINDOW, 16'd4);
    put(CMD_STATUS, POWER, NONE);
    repeat (4) put(CMD_TICK, NONE, ALL);
    put(CMD_STATUS, POWER, ALL);
    put(CMD_STATUS, POWER, NONE);
    put(CMD_STATUS, MINUS | PLUS, NONE);
    repeat (3) put(CMD_TICK, NONE, NONE);
    put(CMD_STATUS, ALL, ALL);
    drain();

    // Zero thresholds: fire on the first tick, never a double press
    write_reg(REG_LONG_PRESS, 16'd0);
    write_reg(REG_DOUBLE_WINDOW, 16'd0);
    put(CMD_STATUS, PLAY, NONE);
    put(CMD_TICK, NONE, NONE);
    put(CMD_STATUS, PLAY, ALL);
    put(CMD_STATUS, PLAY, NONE);
    put(CMD_STATUS, PLAY, ALL);
    drain();

    // Largest thresholds: a short hold never fires and the history stays
    write_reg(REG_LONG_PRESS, 16'hFFFF);
    write_reg(REG_DOUBLE_WINDOW, 16'hFFFF);
    put(CMD_STATUS, MINUS | PLUS, NONE);
    repeat (40) put(CMD_TICK, NONE, NONE);
    put(CMD_STATUS, MINUS | PLUS, ALL);
    put(CMD_STATUS, MINUS | PLUS, NONE);
    put(CMD_STATUS, ALL, ALL);
    drain();

    // Random traffic over a spread of register settings, last phase at full rate
    for (p = 0; p < 8; p++) begin
      write_reg(REG_LONG_PRESS, long_set[p]);
      write_reg(REG_DOUBLE_WINDOW, window_set[p]);
      idle_on = ($urandom_range(0, 3) != 0);
      quiet = (p == 7);
      for (n = 0; n < 150; n++) put_random();
      drain();
    end

    repeat (5) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/bgd_pkg.sv
rtl/bgd_lane.sv
rtl/bgd_combo.sv
rtl/button_gesture_detector.sv
tb/tb_top.sv
